/* src/ssc_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssc_pkg: shared types and constants
// Types and constants for the sphere/sphere contact pipeline and its cells.
// ---------------------------------------------------------------------------
package ssc_pkg;

	localparam int COORD_W   = 31;            // world centre, signed Q14.16
	localparam int RAD_W     = 30;            // radius, unsigned Q14.16
	localparam int MAG_W     = 32;            // |B - A| per axis
	localparam int RSUM_W    = 31;
	localparam int SQ_W      = 64;            // squared distance, Q32.32
	localparam int ROOT_W    = 32;            // distance, Q16.16
	localparam int REM_W     = 35;            // square root partial remainder
	localparam int DIV_W     = 48;            // normal numerator / divisor
	localparam int Q_W       = 17;            // normal quotient
	localparam int NORM_W    = 18;            // normal, signed Q1.16
	localparam int PROD_W    = 47;            // |n| * radius_a
	localparam int POINT_W   = 32;
	localparam int PEN_W     = 31;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 17;
	localparam int NEAR_LIMIT = 6;
	localparam logic [Q_W-1:0] ONE_Q16 = 17'd65536;

	localparam int IN_W  = 248;
	localparam int OUT_W = 184;

	// Item context that travels alongside the arithmetic cells
	typedef struct packed {
		logic                           hit;
		logic [2:0][COORD_W-1:0]        ca;
		logic [2:0]                     neg;
		logic [2:0][MAG_W-1:0]          mag;
		logic [RAD_W-1:0]               ra;
		logic [RSUM_W-1:0]              rsum;
	} ctx_t;

	// Square root cell state
	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [SQ_W-1:0]   rad;
	} sqrt_st_t;

	// Division cell state, three lanes sharing one divisor
	typedef struct packed {
		logic [2:0][DIV_W-1:0] rem;
		logic [2:0][Q_W-1:0]   q;
		logic [DIV_W-1:0]      dv;
		logic [ROOT_W-1:0]     dlen;
	} div_st_t;

endpackage

/* src/ssc_sqrt_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssc_sqrt_cell: one digit of the integer square root
// Takes the top two radicand bits, resolves one root bit, shifts on.
// ---------------------------------------------------------------------------
module ssc_sqrt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vld_i,
	input  ssc_pkg::ctx_t      ctx_i,
	input  ssc_pkg::sqrt_st_t  st_i,
	output logic               vld_o,
	output ssc_pkg::ctx_t      ctx_o,
	output ssc_pkg::sqrt_st_t  st_o
);

	logic [ssc_pkg::REM_W-1:0] r2;
	logic [ssc_pkg::REM_W-1:0] trial;
	logic                      take;

	assign r2    = {st_i.rem[ssc_pkg::REM_W-3:0], st_i.rad[ssc_pkg::SQ_W-1 -: 2]};
	assign trial = {1'b0, st_i.root, 2'b01};
	assign take  = (r2 >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_o     <= ctx_i;
			st_o.rem  <= take ? (r2 - trial) : r2;
			st_o.root <= {st_i.root[ssc_pkg::ROOT_W-2:0], take};
			st_o.rad  <= {st_i.rad[ssc_pkg::SQ_W-3:0], 2'b00};
		end
	end

endmodule

/* src/ssc_div_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssc_div_cell: one quotient bit of the three normal divisions
// Restoring step on each lane; the shared divisor halves per cell.
// ---------------------------------------------------------------------------
module ssc_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_i,
	input  ssc_pkg::ctx_t     ctx_i,
	input  ssc_pkg::div_st_t  st_i,
	output logic              vld_o,
	output ssc_pkg::ctx_t     ctx_o,
	output ssc_pkg::div_st_t  st_o
);

	logic [2:0] take;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			take[i] = (st_i.rem[i] >= st_i.dv);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_o   <= ctx_i;
			for (int i = 0; i < 3; i++) begin
				st_o.rem[i] <= take[i] ? (st_i.rem[i] - st_i.dv) : st_i.rem[i];
				st_o.q[i]   <= {st_i.q[i][ssc_pkg::Q_W-2:0], take[i]};
			end
			st_o.dv   <= {1'b0, st_i.dv[ssc_pkg::DIV_W-1:1]};
			st_o.dlen <= st_i.dlen;
		end
	end

endmodule

/* src/sphere_sphere_contact_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sphere_sphere_contact_top: sphere/sphere contact test and manifold
// Hit test, unit normal, contact point and penetration, fully pipelined.
// ---------------------------------------------------------------------------
// Registered path: stages 1 to 3, the square root cells, the divider cells, then stages 5 to 7.
// Throughput: one word per cycle while the pipe is not stalled; every stage
// and every root and divider cell takes a new word each cycle that it advances.
// The whole pipe advances together; it stalls only while the output word
// waits and the downstream side is not ready.
// Reset (arst_n low) clears all valid bits at once; payload is not reset.
// ---------------------------------------------------------------------------
module sphere_sphere_contact_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// from bit 0: center_a_x[31], center_a_y[31], center_a_z[31], radius_a[30],
	// center_b_x[31], center_b_y[31], center_b_z[31], radius_b[30], zero pad[2]
	input  logic [ssc_pkg::IN_W-1:0]    s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// from bit 0: hit[1], normal_x[18], normal_y[18], normal_z[18],
	// point_x[32], point_y[32], point_z[32], penetration[31], zero pad[2]
	output logic [ssc_pkg::OUT_W-1:0]   m_axis_tdata
);

	// global advance: everything moves unless the output word is held
	logic en;
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// ---------------- input unpacking ----------------
	logic signed [ssc_pkg::COORD_W-1:0] in_a [3];
	logic signed [ssc_pkg::COORD_W-1:0] in_b [3];
	logic        [ssc_pkg::RAD_W-1:0]   in_ra, in_rb;

	assign in_a[0] = s_axis_tdata[30:0];
	assign in_a[1] = s_axis_tdata[61:31];
	assign in_a[2] = s_axis_tdata[92:62];
	assign in_ra   = s_axis_tdata[122:93];
	assign in_b[0] = s_axis_tdata[153:123];
	assign in_b[1] = s_axis_tdata[184:154];
	assign in_b[2] = s_axis_tdata[215:185];
	assign in_rb   = s_axis_tdata[245:216];

	// ---------------- stage 1: delta B - A, magnitude, radius sum ----------------
	logic          v_s1;
	ssc_pkg::ctx_t ctx_s1;
	logic signed [ssc_pkg::MAG_W-1:0] dlt [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dlt[i] = ssc_pkg::MAG_W'(in_b[i]) - ssc_pkg::MAG_W'(in_a[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1.hit  <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				ctx_s1.ca[i]  <= in_a[i];
				ctx_s1.neg[i] <= dlt[i][ssc_pkg::MAG_W-1];
				ctx_s1.mag[i] <= dlt[i][ssc_pkg::MAG_W-1] ? (-dlt[i]) : dlt[i];
			end
			ctx_s1.ra   <= in_ra;
			ctx_s1.rsum <= ssc_pkg::RSUM_W'(in_ra) + ssc_pkg::RSUM_W'(in_rb);
		end
	end

	// ---------------- stage 2: squares ----------------
	logic          v_s2;
	ssc_pkg::ctx_t ctx_s2;
	logic [ssc_pkg::SQ_W-1:0] sq_s2 [3];
	logic [ssc_pkg::SQ_W-1:0] rsq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s2 <= ctx_s1;
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= ctx_s1.mag[i] * ctx_s1.mag[i];
			end
			rsq_s2 <= ssc_pkg::SQ_W'(ctx_s1.rsum) * ssc_pkg::SQ_W'(ctx_s1.rsum);
		end
	end

	// ---------------- stage 3: squared distance and strict overlap ----------------
	logic                     v_s3;
	ssc_pkg::ctx_t            ctx_s3;
	ssc_pkg::ctx_t            ctx_hit;
	logic [ssc_pkg::SQ_W-1:0] dsq;
	logic [ssc_pkg::SQ_W-1:0] dsq_s3;

	assign dsq = sq_s2[0] + sq_s2[1] + sq_s2[2];

	always_comb begin
		ctx_hit     = ctx_s2;
		ctx_hit.hit = (dsq < rsq_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s3     <= ctx_hit;
			dsq_s3     <= dsq;
		end
	end

	// ---------------- square root chain: one root bit per cell ----------------
	logic              [ssc_pkg::SQRT_STEPS:0] sq_vld;
	ssc_pkg::ctx_t     sq_ctx [ssc_pkg::SQRT_STEPS+1];
	ssc_pkg::sqrt_st_t sq_st  [ssc_pkg::SQRT_STEPS+1];

	assign sq_vld[0]        = v_s3;
	assign sq_ctx[0]        = ctx_s3;
	assign sq_st[0].rem     = '0;
	assign sq_st[0].root    = '0;
	assign sq_st[0].rad     = dsq_s3;

	for (genvar g = 0; g < ssc_pkg::SQRT_STEPS; g++) begin : g_sqrt
		ssc_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (sq_vld[g]),
			.ctx_i  (sq_ctx[g]),
			.st_i   (sq_st[g]),
			.vld_o  (sq_vld[g+1]),
			.ctx_o  (sq_ctx[g+1]),
			.st_o   (sq_st[g+1])
		);
	end

	// ---------------- divider chain: normal = |d| * 2^16 / dlen, rounded ----------------
	// numerator carries + dlen/2 for round-to-nearest; divisor starts at dlen << 16
	logic [ssc_pkg::ROOT_W-1:0] dlen;
	logic                       [ssc_pkg::DIV_STEPS:0] dv_vld;
	ssc_pkg::ctx_t              dv_ctx [ssc_pkg::DIV_STEPS+1];
	ssc_pkg::div_st_t           dv_st  [ssc_pkg::DIV_STEPS+1];

	assign dlen      = sq_st[ssc_pkg::SQRT_STEPS].root;
	assign dv_vld[0] = sq_vld[ssc_pkg::SQRT_STEPS];
	assign dv_ctx[0] = sq_ctx[ssc_pkg::SQRT_STEPS];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dv_st[0].rem[i] = {dv_ctx[0].mag[i], 16'd0}
			                  + ssc_pkg::DIV_W'(dlen[ssc_pkg::ROOT_W-1:1]);
			dv_st[0].q[i]   = '0;
		end
		dv_st[0].dv   = {dlen, 16'd0};
		dv_st[0].dlen = dlen;
	end

	for (genvar g = 0; g < ssc_pkg::DIV_STEPS; g++) begin : g_div
		ssc_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (dv_vld[g]),
			.ctx_i  (dv_ctx[g]),
			.st_i   (dv_st[g]),
			.vld_o  (dv_vld[g+1]),
			.ctx_o  (dv_ctx[g+1]),
			.st_o   (dv_st[g+1])
		);
	end

	// ---------------- stage 5: cap, sign, near-coincident override, penetration ----------------
	ssc_pkg::ctx_t              dctx;
	ssc_pkg::div_st_t           dst;
	logic                       near;
	logic                       v_s5;
	logic                       hit_s5;
	logic [2:0][ssc_pkg::COORD_W-1:0] ca_s5;
	logic [ssc_pkg::RAD_W-1:0]  ra_s5;
	logic [ssc_pkg::Q_W-1:0]    nmag_s5 [3];
	logic [2:0]                 nneg_s5;
	logic [ssc_pkg::PEN_W-1:0]  pen_s5;

	assign dctx = dv_ctx[ssc_pkg::DIV_STEPS];
	assign dst  = dv_st[ssc_pkg::DIV_STEPS];
	assign near = (dst.dlen <= ssc_pkg::ROOT_W'(ssc_pkg::NEAR_LIMIT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= dv_vld[ssc_pkg::DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s5 <= dctx.hit;
			ca_s5  <= dctx.ca;
			ra_s5  <= dctx.ra;
			pen_s5 <= dctx.rsum - ssc_pkg::RSUM_W'(dst.dlen);
			for (int i = 0; i < 3; i++) begin
				if (near) begin
					nmag_s5[i] <= (i == 1) ? ssc_pkg::ONE_Q16 : '0;
					nneg_s5[i] <= 1'b0;
				end else begin
					nmag_s5[i] <= (dst.q[i] > ssc_pkg::ONE_Q16) ? ssc_pkg::ONE_Q16 : dst.q[i];
					nneg_s5[i] <= dctx.neg[i];
				end
			end
		end
	end

	// ---------------- stage 6: |n| * radius_a ----------------
	logic                        v_s6;
	logic                        hit_s6;
	logic [2:0][ssc_pkg::COORD_W-1:0] ca_s6;
	logic [ssc_pkg::PROD_W-1:0]  prod_s6 [3];
	logic signed [ssc_pkg::NORM_W-1:0] n_s6 [3];
	logic [2:0]                  nneg_s6;
	logic [ssc_pkg::PEN_W-1:0]   pen_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s6  <= hit_s5;
			ca_s6   <= ca_s5;
			pen_s6  <= pen_s5;
			nneg_s6 <= nneg_s5;
			for (int i = 0; i < 3; i++) begin
				prod_s6[i] <= ssc_pkg::PROD_W'(nmag_s5[i]) * ssc_pkg::PROD_W'(ra_s5);
				n_s6[i]    <= nneg_s5[i] ? -ssc_pkg::NORM_W'(nmag_s5[i])
				                         :  ssc_pkg::NORM_W'(nmag_s5[i]);
			end
		end
	end

	// ---------------- stage 7: round, offset from centre A, saturate ----------------
	logic [ssc_pkg::PROD_W:0]          rnd   [3];
	logic signed [ssc_pkg::POINT_W+1:0] sum  [3];
	logic signed [ssc_pkg::POINT_W-1:0] sat  [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd[i] = {1'b0, prod_s6[i]} + (ssc_pkg::PROD_W+1)'(17'h08000);
			sum[i] = (ssc_pkg::POINT_W+2)'(signed'(ca_s6[i]))
			         + (nneg_s6[i] ? -(ssc_pkg::POINT_W+2)'(rnd[i][ssc_pkg::PROD_W:16])
			                       :  (ssc_pkg::POINT_W+2)'(rnd[i][ssc_pkg::PROD_W:16]));
			if (sum[i][ssc_pkg::POINT_W+1:ssc_pkg::POINT_W-1] == 3'b000
			    || sum[i][ssc_pkg::POINT_W+1:ssc_pkg::POINT_W-1] == 3'b111) begin
				sat[i] = sum[i][ssc_pkg::POINT_W-1:0];
			end else if (sum[i][ssc_pkg::POINT_W+1]) begin
				sat[i] = {1'b1, {(ssc_pkg::POINT_W-1){1'b0}}};
			end else begin
				sat[i] = {1'b0, {(ssc_pkg::POINT_W-1){1'b1}}};
			end
		end
	end

	logic                               hit_s7;
	logic signed [ssc_pkg::NORM_W-1:0]  n_s7 [3];
	logic signed [ssc_pkg::POINT_W-1:0] p_s7 [3];
	logic [ssc_pkg::PEN_W-1:0]          pen_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= v_s6;
		end
	end

	// no hit: every result field reads zero
	always_ff @(posedge clk) begin
		if (en) begin
			hit_s7 <= hit_s6;
			pen_s7 <= hit_s6 ? pen_s6 : '0;
			for (int i = 0; i < 3; i++) begin
				n_s7[i] <= hit_s6 ? n_s6[i] : '0;
				p_s7[i] <= hit_s6 ? sat[i]  : '0;
			end
		end
	end

	assign m_axis_tdata = {2'b00, pen_s7, p_s7[2], p_s7[1], p_s7[0],
	                       n_s7[2], n_s7[1], n_s7[0], hit_s7};

endmodule
